### rtl/drsq_pkg.sv
// Shared types and constants for the deadline-sorted ready queue.
// No dependencies; the interfaces and the top level import this package.
package drsq_pkg;

  localparam int DEPTH_DEF          = 16;
  localparam int NUM_QUEUES_DEF     = 4;
  localparam int DEADLINE_WIDTH_DEF = 16;

  localparam int MODE_W = 1;
  localparam int QSEL_W = 2;
  localparam int ID_W   = 8;
  localparam int DL_W   = 16;
  localparam int POS_W  = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
  localparam logic [MODE_W-1:0] MODE_POP    = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [QSEL_W-1:0] queue_sel;
    logic [ID_W-1:0]   proc_id;
    logic [DL_W-1:0]   deadline;
  } cmd_item_t;

  typedef struct packed {
    logic              accepted;
    logic              full_res;
    logic [POS_W-1:0]  position;
    logic              head_valid;
    logic [ID_W-1:0]   head_id;
    logic [DL_W-1:0]   head_deadline;
  } rsp_item_t;

endpackage

### rtl/drsq_in_if.sv
// Command channel of the ready queue: valid/ready plus one operation.
// Depends on drsq_pkg for the payload type.
interface drsq_in_if;
  import drsq_pkg::*;

  logic      valid;
  logic      ready;
  cmd_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/drsq_out_if.sv
// Result channel of the ready queue: valid/ready plus one result item.
// Depends on drsq_pkg for the payload type.
interface drsq_out_if;
  import drsq_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/drsq_slot_ram.sv
// Slot store shared by all queues: one write port, one read port,
// registered read data. No package dependencies beyond its parameters.
module drsq_slot_ram #(
  parameter int SLOTS = 64,
  parameter int DW    = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(SLOTS)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(SLOTS)-1:0] raddr,
  output logic [DW-1:0]            rdata
);
  logic [DW-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/drsq_cmp.sv
// Shared deadline compare unit: tells whether a stored entry must yield
// to a new deadline. Used once per scan step by the sequencer.
module drsq_cmp #(
  parameter int DLW = 16
) (
  input  logic [DLW-1:0] slot_dl,
  input  logic [DLW-1:0] key,
  output logic           move
);
  // A keyless insert never passes anything; otherwise pass entries with no
  // deadline or a later one, so ties keep arrival order.
  assign move = (key != '0) && ((slot_dl == '0) || (slot_dl > key));
endmodule

### rtl/deadline_sorted_ready_queue.sv
// Deadline-sorted ready queue, top level: sequencer, slot store, compare unit.
// Depends on drsq_pkg, drsq_in_if, drsq_out_if, drsq_slot_ram and drsq_cmp.
//
// Usage: cmd carries one operation (insert proc_id/deadline, or pop) for the
// queue picked by queue_sel; rsp returns one result per command, in order.
// Each queue is kept sorted by earliest deadline, deadline 0 at the tail.
// Entries live in one single-port-read, single-port-write slot memory, so
// the sequencer moves each entry with a read step, then a write-back step.
// cmd.ready is high only while the sequencer is idle; a command is taken only
// after the result of the one before it is loaded into the output register.
// Steps: an insert scans from the tail toward its slot, moving each later entry
// back one slot, then reads the head; an insert into a full queue only reads
// the head; a pop reads the head, then shifts the remaining entries forward;
// a bad queue or an empty pop goes straight to the result.
// The next command is taken the cycle after the result is loaded into the
// output register. A result waits there until rsp.ready; a command may be
// taken meanwhile, and its own result holds until the register frees up.
// Reset (rst, synchronous) empties every queue and drops a pending result;
// the slot memory itself is not cleared, only slots below a count are used.
module deadline_sorted_ready_queue #(
  parameter int DEPTH          = drsq_pkg::DEPTH_DEF,
  parameter int NUM_QUEUES     = drsq_pkg::NUM_QUEUES_DEF,
  parameter int DEADLINE_WIDTH = drsq_pkg::DEADLINE_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst,
  drsq_in_if.sink      cmd,
  drsq_out_if.source   rsp
);
  import drsq_pkg::*;

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SLOTS = NUM_QUEUES * DEPTH;
  localparam int MW    = $clog2(SLOTS);
  localparam int DW    = ID_W + DEADLINE_WIDTH;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN_RD   = 3'd1;
  localparam logic [2:0] S_SCAN_WR   = 3'd2;
  localparam logic [2:0] S_HEAD_RD   = 3'd3;
  localparam logic [2:0] S_HEAD_WAIT = 3'd4;
  localparam logic [2:0] S_POP_RD    = 3'd5;
  localparam logic [2:0] S_POP_WR    = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  logic [2:0]                state;
  logic [MODE_W-1:0]         mode_r;
  logic [ID_W-1:0]           pid_r;
  logic [DEADLINE_WIDTH-1:0] key_r;
  logic [CW-1:0]             cnt_r;
  logic [CW-1:0]             idx;
  logic [MW-1:0]             base;
  logic [CW-1:0]             queue_count [NUM_QUEUES];

  logic                      res_acc;
  logic                      res_full;
  logic                      res_hv;
  logic [CW-1:0]             res_pos;
  logic [ID_W-1:0]           res_id;
  logic [DEADLINE_WIDTH-1:0] res_dl;

  logic                      out_valid;
  rsp_item_t                 out_item;

  logic                      take;
  logic                      q_ok;
  logic [QW-1:0]             q_in;
  logic [CW-1:0]             cnt_in;
  logic [MW-1:0]             base_in;

  logic                      ram_we;
  logic [MW-1:0]             ram_waddr;
  logic [DW-1:0]             ram_wdata;
  logic [MW-1:0]             ram_raddr;
  logic [DW-1:0]             ram_rdata;
  logic [DEADLINE_WIDTH-1:0] rd_dl;
  logic                      move;

  assign cmd.ready   = (state == S_IDLE);
  assign take        = cmd.valid && cmd.ready;
  assign q_ok        = int'(cmd.payload.queue_sel) < NUM_QUEUES;
  assign q_in        = QW'(cmd.payload.queue_sel);
  assign cnt_in      = q_ok ? queue_count[q_in] : '0;
  assign base_in     = MW'(MW'(q_in) * MW'(DEPTH));
  assign rd_dl       = ram_rdata[DEADLINE_WIDTH-1:0];

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;

  drsq_slot_ram #(
    .SLOTS (SLOTS),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  drsq_cmp #(
    .DLW (DEADLINE_WIDTH)
  ) u_cmp (
    .slot_dl (rd_dl),
    .key     (key_r),
    .move    (move)
  );

  // Memory port control per sequencer step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base + MW'(idx);
    ram_wdata = {pid_r, key_r};
    ram_raddr = base;
    unique case (state)
      S_SCAN_RD: begin
        if (idx == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_raddr = base + MW'(idx - ONE_C);
        end
      end
      S_SCAN_WR: begin
        ram_we = 1'b1;
        if (move) begin
          ram_wdata = ram_rdata;
        end
      end
      S_POP_RD: begin
        ram_raddr = base + MW'(idx);
      end
      S_POP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = base + MW'(idx - ONE_C);
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int k = 0; k < NUM_QUEUES; k++) begin
        queue_count[k] <= '0;
      end
    end else begin
      // drop the transfer here unless a new result is loaded this cycle
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            mode_r   <= cmd.payload.mode;
            pid_r    <= cmd.payload.proc_id;
            key_r    <= DEADLINE_WIDTH'(cmd.payload.deadline);
            cnt_r    <= cnt_in;
            base     <= base_in;
            res_pos  <= '0;
            res_id   <= '0;
            res_dl   <= '0;
            res_acc  <= 1'b0;
            res_full <= 1'b0;
            res_hv   <= 1'b0;
            if (!q_ok) begin
              state <= S_DONE;
            end else if (cmd.payload.mode == MODE_POP) begin
              if (cnt_in == '0) begin
                state <= S_DONE;
              end else begin
                res_acc           <= 1'b1;
                res_hv            <= (cnt_in != ONE_C);
                queue_count[q_in] <= cnt_in - ONE_C;
                state             <= S_HEAD_RD;
              end
            end else if (cnt_in == DEPTH_C) begin
              // drop the insert, report the current head
              res_full <= 1'b1;
              res_hv   <= 1'b1;
              state    <= S_HEAD_RD;
            end else begin
              res_acc           <= 1'b1;
              res_hv            <= 1'b1;
              idx               <= cnt_in;
              queue_count[q_in] <= cnt_in + ONE_C;
              state             <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          // at slot 0 the new entry was written this cycle
          state <= (idx == '0) ? S_HEAD_RD : S_SCAN_WR;
        end
        S_SCAN_WR: begin
          if (move) begin
            idx   <= idx - ONE_C;
            state <= S_SCAN_RD;
          end else begin
            res_pos <= idx;
            state   <= S_HEAD_RD;
          end
        end
        S_HEAD_RD: begin
          state <= S_HEAD_WAIT;
        end
        S_HEAD_WAIT: begin
          res_id <= ram_rdata[DW-1 -: ID_W];
          res_dl <= rd_dl;
          if (mode_r == MODE_POP) begin
            idx   <= ONE_C;
            state <= S_POP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_POP_RD: begin
          state <= (idx == cnt_r) ? S_DONE : S_POP_WR;
        end
        S_POP_WR: begin
          idx   <= idx + ONE_C;
          state <= S_POP_RD;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid              <= 1'b1;
            out_item.accepted      <= res_acc;
            out_item.full_res      <= res_full;
            out_item.position      <= POS_W'(res_pos);
            out_item.head_valid    <= res_hv;
            out_item.head_id       <= res_id;
            out_item.head_deadline <= DL_W'(res_dl);
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    take |=> !cmd.ready)
    else $error("command taken while a previous one is still in work");

  a_scan_not_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_WR) |-> (idx != '0))
    else $error("scan compare step reached at slot 0");

  a_pop_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_RD) |-> ((idx <= cnt_r) && (idx != '0)))
    else $error("pop shift index outside the queue");

  a_full_not_acc: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.payload.accepted && rsp.payload.full_res))
    else $error("result both accepted and dropped as full");

endmodule

### bench/deadline_sorted_ready_queue_tb.sv
`timescale 1ns / 1ps
// Testbench for deadline_sorted_ready_queue: directed and random insert/pop traffic.
// Depends on drsq_pkg, drsq_in_if, drsq_out_if and the block's RTL.
module deadline_sorted_ready_queue_tb;
  import drsq_pkg::*;

  typedef enum {RDY_OPEN, RDY_COIN, RDY_STARVE} rdy_mode_e;

  logic clk;
  logic rst;

  drsq_in_if  cmd_ch ();
  drsq_out_if rsp_ch ();

  deadline_sorted_ready_queue dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the ready queues
  logic [ID_W-1:0] shadow_id [NUM_QUEUES_DEF][DEPTH_DEF];
  logic [DL_W-1:0] shadow_dl [NUM_QUEUES_DEF][DEPTH_DEF];
  int              shadow_cnt [NUM_QUEUES_DEF];

  rsp_item_t   outcome_q [$];
  int          mismatches = 0;
  int unsigned burst_left = 0;
  rdy_mode_e   rdy_mode = RDY_OPEN;
  int unsigned rdy_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("[deadline_sorted_ready_queue] ERROR");
    $finish;
  end

  // Apply one operation to the shadow queues and return the result it yields.
  function automatic rsp_item_t edf_apply(input cmd_item_t c);
    rsp_item_t r;
    int q, n, p, i;
    r = '0;
    q = int'(c.queue_sel);
    n = shadow_cnt[q];
    if (c.mode == MODE_POP) begin
      if (n == 0) return r;
      r.accepted      = 1'b1;
      r.head_id       = shadow_id[q][0];
      r.head_deadline = shadow_dl[q][0];
      for (i = 0; i + 1 < n; i++) begin
        shadow_id[q][i] = shadow_id[q][i+1];
        shadow_dl[q][i] = shadow_dl[q][i+1];
      end
      shadow_cnt[q] = n - 1;
      r.head_valid  = (n - 1) != 0;
    end else if (n >= DEPTH_DEF) begin
      r.full_res      = 1'b1;
      r.head_valid    = 1'b1;
      r.head_id       = shadow_id[q][0];
      r.head_deadline = shadow_dl[q][0];
    end else begin
      // Land in front of the first later deadline or no-deadline entry; a no-deadline insert goes last
      p = n;
      if (c.deadline != '0) begin
        for (i = 0; i < n; i++) begin
          if (shadow_dl[q][i] == '0 || shadow_dl[q][i] > c.deadline) begin
            p = i;
            break;
          end
        end
      end
      for (i = n; i > p; i--) begin
        shadow_id[q][i] = shadow_id[q][i-1];
        shadow_dl[q][i] = shadow_dl[q][i-1];
      end
      shadow_id[q][p] = c.proc_id;
      shadow_dl[q][p] = c.deadline;
      shadow_cnt[q]   = n + 1;
      r.accepted      = 1'b1;
      r.position      = POS_W'(p);
      r.head_valid    = 1'b1;
      r.head_id       = shadow_id[q][0];
      r.head_deadline = shadow_dl[q][0];
    end
    return r;
  endfunction

  function automatic cmd_item_t mk_cmd(input logic [MODE_W-1:0] mode, input int q,
                                       input int id, input int dl);
    cmd_item_t c;
    c.mode      = mode;
    c.queue_sel = QSEL_W'(q);
    c.proc_id   = ID_W'(id);
    c.deadline  = DL_W'(dl);
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Drive one command, honoring the burst/gap pattern; predict on transfer.
  task automatic send_cmd(input cmd_item_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(30, 60);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 10);
        gap        = $urandom_range(1, 12);
      end
      if (gap != 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_ch.payload <= c;
    cmd_ch.valid   <= 1'b1;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    outcome_q.push_back(edf_apply(c));
  endtask

  task automatic hold_cmd();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_order();
    send_cmd(mk_cmd(MODE_POP,    0, 8'h00, 0));
    send_cmd(mk_cmd(MODE_INSERT, 3, 8'h00, 0));
    send_cmd(mk_cmd(MODE_INSERT, 3, 8'hFF, 16'hFFFF));
    send_cmd(mk_cmd(MODE_INSERT, 3, 8'h11, 1));
    send_cmd(mk_cmd(MODE_INSERT, 3, 8'h21, 100));
    send_cmd(mk_cmd(MODE_INSERT, 3, 8'h22, 100));
    send_cmd(mk_cmd(MODE_INSERT, 3, 8'h30, 0));
    send_cmd(mk_cmd(MODE_INSERT, 3, 8'h12, 1));
    send_cmd(mk_cmd(MODE_INSERT, 3, 8'h40, 16'hFFFF));
  endtask

  task automatic test_full_queue();
    int dl_list [8] = '{5, 0, 100, 2, 16'hFFFF, 7, 0, 3};
    int i;
    for (i = 0; i < 8; i++) send_cmd(mk_cmd(MODE_INSERT, 3, 8'h50 + i, dl_list[i]));
    send_cmd(mk_cmd(MODE_INSERT, 3, 8'hEE, 1));
    send_cmd(mk_cmd(MODE_POP,    3, 8'h00, 0));
    send_cmd(mk_cmd(MODE_POP,    3, 8'hFF, 16'hFFFF));
    // single entry: pop leaves the queue empty
    send_cmd(mk_cmd(MODE_INSERT, 1, 8'hAA, 16'h8000));
    send_cmd(mk_cmd(MODE_POP,    1, 8'h55, 16'h7FFF));
  endtask

  task automatic test_random_traffic(input int first_phase, input int last_phase);
    int pop_pct [6] = '{30, 50, 20, 65, 15, 45};
    int q_span  [6] = '{3, 1, 0, 3, 2, 3};
    int ph, k, sel, dl;
    logic [MODE_W-1:0] mode;
    for (ph = first_phase; ph <= last_phase; ph++) begin
      for (k = 0; k < 64; k++) begin
        mode = ($urandom_range(0, 99) < pop_pct[ph]) ? MODE_POP : MODE_INSERT;
        sel  = $urandom_range(0, 9);
        // favor small deadlines so ties are common
        if (sel < 2)      dl = 0;
        else if (sel < 6) dl = $urandom_range(1, 8);
        else if (sel < 8) dl = $urandom_range(1, 16'hFFFF);
        else if (sel < 9) dl = 16'hFFFF;
        else              dl = $urandom & 16'hFFFF;
        send_cmd(mk_cmd(mode, $urandom_range(0, q_span[ph]), $urandom_range(0, 255), dl));
      end
    end
  endtask

  task automatic test_drain_pause();
    hold_cmd();
    wait_drained();
    send_cmd(mk_cmd(MODE_POP, 0, 8'h00, 0));
  endtask

  // Receiver back-pressure on a pattern of its own
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode = rdy_mode_e'($urandom_range(0, 2));
        rdy_left = $urandom_range(32, 200);
      end
      rdy_left--;
      case (rdy_mode)
        RDY_OPEN: begin
          rsp_ch.ready <= 1'b1;
        end
        RDY_COIN: begin
          rsp_ch.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          rsp_ch.ready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    rsp_item_t want;
    rsp_item_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.payload;
      if (outcome_q.size() == 0) begin
        report_mismatch("expected results pending", 32'(0), 32'(1));
      end else begin
        want = outcome_q.pop_front();
        if (got.accepted !== want.accepted)
          report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
        if (got.full_res !== want.full_res)
          report_mismatch("full_res", 32'(got.full_res), 32'(want.full_res));
        if (got.position !== want.position)
          report_mismatch("position", 32'(got.position), 32'(want.position));
        if (got.head_valid !== want.head_valid)
          report_mismatch("head_valid", 32'(got.head_valid), 32'(want.head_valid));
        if (got.head_id !== want.head_id)
          report_mismatch("head_id", 32'(got.head_id), 32'(want.head_id));
        if (got.head_deadline !== want.head_deadline)
          report_mismatch("head_deadline", 32'(got.head_deadline),
                          32'(want.head_deadline));
      end
    end
  end

  initial begin
    for (int q = 0; q < NUM_QUEUES_DEF; q++) shadow_cnt[q] = 0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    rst            = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_order();
    test_full_queue();
    test_random_traffic(0, 2);
    test_drain_pause();
    test_random_traffic(3, 5);
    hold_cmd();
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("[deadline_sorted_ready_queue] OK");
    end else begin
      $display("[deadline_sorted_ready_queue] ERROR");
    end
    $finish;
  end
endmodule
